// ===== hw/rtl/mqps_pkg.sv =====
package mqps_pkg;

  localparam int unsigned NUM_PATHS  = 8;
  localparam int unsigned QUEUE_BITS = 16;
  localparam int unsigned IDX_W      = $clog2(NUM_PATHS);
  localparam int unsigned CNT_W      = $clog2(NUM_PATHS + 1);

  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_SELECT = 2'd1;
  localparam logic [1:0] ACT_REWIND = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  localparam logic [1:0] CFG_PATH_COUNT = 2'd0;
  localparam logic [1:0] CFG_POLICY     = 2'd1;
  localparam logic [1:0] CFG_DISABLED   = 2'd2;
  localparam logic [1:0] CFG_MAIN_USE   = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             sticky;
    logic             main_usable;
    logic             cursor_set;
    logic [IDX_W-1:0] cursor_idx;
  } scan_ctx_t;

  typedef struct packed {
    logic                  valid;
    logic                  done;
    logic                  prev_valid;
    logic [IDX_W-1:0]      prev;
    logic                  window;
    logic                  have_min;
    logic [IDX_W-1:0]      min_idx;
    logic [QUEUE_BITS-1:0] min_q;
    logic                  have_best;
    logic [IDX_W-1:0]      best_idx;
    logic [QUEUE_BITS-1:0] best_q;
    logic                  have_first;
    logic [IDX_W-1:0]      first_idx;
    logic                  have_from;
    logic [IDX_W-1:0]      from_idx;
  } scan_tok_t;

endpackage

// ===== hw/rtl/mqps_cell.sv =====
module mqps_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mqps_pkg::IDX_W-1:0]     cell_idx_i,
  input  logic                           wr_en_i,
  input  logic [mqps_pkg::IDX_W-1:0]     wr_idx_i,
  input  logic                           wr_active_i,
  input  logic [mqps_pkg::QUEUE_BITS-1:0] wr_queue_i,
  input  mqps_pkg::scan_ctx_t            ctx_i,
  input  mqps_pkg::scan_tok_t            tok_i,
  output mqps_pkg::scan_tok_t            tok_o
);
  import mqps_pkg::*;

  logic                  active_q;
  logic [QUEUE_BITS-1:0] queue_q;
  scan_tok_t             tok_d;
  scan_tok_t             tok_q;
  logic                  in_use;
  logic                  match;
  logic                  win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      queue_q  <= '0;
    end else if (wr_en_i && (wr_idx_i == cell_idx_i)) begin
      active_q <= wr_active_i;
      queue_q  <= wr_queue_i;
    end
  end

  always_comb begin
    tok_d  = tok_i;
    in_use = ({1'b0, cell_idx_i} < ctx_i.n);
    match  = 1'b0;
    win    = 1'b0;
    if (tok_i.valid && in_use) begin
      if (ctx_i.sticky) begin
        if (active_q) begin
          if (!tok_i.have_first) begin
            tok_d.have_first = 1'b1;
            tok_d.first_idx  = cell_idx_i;
          end
          if (!tok_i.have_from && (cell_idx_i >= ctx_i.cursor_idx)) begin
            tok_d.have_from = 1'b1;
            tok_d.from_idx  = cell_idx_i;
          end
        end
      end else if (!tok_i.done && !((cell_idx_i == '0) && !ctx_i.main_usable)) begin
        if (active_q) begin
          if (!tok_i.have_min || (queue_q < tok_i.min_q)) begin
            tok_d.have_min = 1'b1;
            tok_d.min_idx  = cell_idx_i;
            tok_d.min_q    = queue_q;
          end
          match = ctx_i.cursor_set ? (tok_i.prev_valid && (tok_i.prev == ctx_i.cursor_idx))
                                   : !tok_i.prev_valid;
          win = tok_i.window || match;
          tok_d.window = win;
          if (win && (!tok_i.have_best || (queue_q < tok_i.best_q))) begin
            tok_d.have_best = 1'b1;
            tok_d.best_idx  = cell_idx_i;
            tok_d.best_q    = queue_q;
            tok_d.done      = (queue_q == '0);
          end
        end
        tok_d.prev       = cell_idx_i;
        tok_d.prev_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hw/rtl/multipath_queue_aware_path_selector.sv =====
// Update and rewind requests take effect on acceptance and raise no done; a query, or a select with no paths or with
// multipath disabled, puts its result out in the cycle after acceptance.
// Any other select scans the path cells one per cycle with busy high while it scans;
// its result is registered after the last cell, and no new request is accepted until then.
// The receiver cannot stall. Reset is asynchronous and active low: all paths inactive with
// empty queues, no cursor, path count zero and the main path usable.
module multipath_queue_aware_path_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [2:0]  path_index_i,
  input  logic        path_up_i,
  input  logic [15:0] queue_length_i,
  output logic        done_o,
  output logic [2:0]  chosen_path_o,
  output logic        chosen_valid_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import mqps_pkg::*;

  state_e           state_q, state_d;
  logic [3:0]       path_count_q;
  logic             policy_q;
  logic             disabled_q;
  logic             main_use_q;
  logic [IDX_W-1:0] cursor_q, cursor_d;
  logic             cursor_set_q, cursor_set_d;
  logic             done_q, done_d;
  logic [IDX_W-1:0] path_q, path_d;
  logic             pvalid_q, pvalid_d;

  logic             accept;
  logic             wr_en;
  logic             launch;
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] final_idx;
  scan_ctx_t        ctx;
  scan_tok_t        tok [NUM_PATHS+1];

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign n = (path_count_q > 4'(NUM_PATHS)) ? CNT_W'(NUM_PATHS) : CNT_W'(path_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_count_q <= '0;
      policy_q     <= 1'b0;
      disabled_q   <= 1'b0;
      main_use_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATH_COUNT: path_count_q <= cfg_data_i;
        CFG_POLICY:     policy_q     <= cfg_data_i[0];
        CFG_DISABLED:   disabled_q   <= cfg_data_i[0];
        CFG_MAIN_USE:   main_use_q   <= cfg_data_i[0];
        default:        path_count_q <= path_count_q;
      endcase
    end
  end

  always_comb begin
    ctx.n           = n;
    ctx.sticky      = policy_q;
    ctx.main_usable = main_use_q;
    ctx.cursor_set  = cursor_set_q;
    ctx.cursor_idx  = cursor_q;
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch;
  end

  for (genvar k = 0; k < NUM_PATHS; k++) begin : g_cell
    mqps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IDX_W'(k)),
      .wr_en_i     (wr_en),
      .wr_idx_i    (path_index_i[IDX_W-1:0]),
      .wr_active_i (path_up_i),
      .wr_queue_i  (queue_length_i[QUEUE_BITS-1:0]),
      .ctx_i       (ctx),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1])
    );
  end

  always_comb begin
    final_idx = '0;
    if (policy_q) begin
      if (cursor_set_q && (n >= CNT_W'(2)) && ({1'b0, cursor_q} < n) &&
          tok[NUM_PATHS].have_from) begin
        final_idx = tok[NUM_PATHS].from_idx;
      end else if (tok[NUM_PATHS].have_first) begin
        final_idx = tok[NUM_PATHS].first_idx;
      end
    end else if (tok[NUM_PATHS].have_best) begin
      final_idx = tok[NUM_PATHS].best_idx;
    end else if (tok[NUM_PATHS].have_min) begin
      final_idx = tok[NUM_PATHS].min_idx;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_SELECT) && (n != '0) && !disabled_q) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[NUM_PATHS].valid) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_q == ST_SCAN);
    wr_en        = 1'b0;
    launch       = 1'b0;
    cursor_d     = cursor_q;
    cursor_set_d = cursor_set_q;
    done_d       = 1'b0;
    path_d       = '0;
    pvalid_d     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_UPDATE: wr_en = 1'b1;
            ACT_REWIND: cursor_set_d = 1'b0;
            ACT_SELECT: begin
              if (n == '0) begin
                cursor_set_d = 1'b0;
                done_d       = 1'b1;
              end else if (disabled_q) begin
                cursor_d     = '0;
                cursor_set_d = 1'b1;
                done_d       = 1'b1;
                pvalid_d     = 1'b1;
              end else begin
                launch = 1'b1;
              end
            end
            ACT_QUERY: begin
              done_d = 1'b1;
              if (n == '0) begin
                pvalid_d = 1'b0;
              end else if (!cursor_set_q || (n < CNT_W'(2))) begin
                pvalid_d = 1'b1;
              end else if ({1'b0, cursor_q} < n) begin
                path_d   = cursor_q;
                pvalid_d = 1'b1;
              end
            end
            default: wr_en = 1'b0;
          endcase
        end
      end
      ST_SCAN: begin
        if (tok[NUM_PATHS].valid) begin
          cursor_d     = final_idx;
          cursor_set_d = 1'b1;
          done_d       = 1'b1;
          path_d       = final_idx;
          pvalid_d     = 1'b1;
        end
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cursor_q     <= '0;
      cursor_set_q <= 1'b0;
      done_q       <= 1'b0;
      path_q       <= '0;
      pvalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      cursor_set_q <= cursor_set_d;
      done_q       <= done_d;
      path_q       <= path_d;
      pvalid_q     <= pvalid_d;
    end
  end

  assign done_o         = done_q;
  assign chosen_path_o  = 3'(path_q);
  assign chosen_valid_o = pvalid_q;

endmodule
